// File: hdl/sorted_key_record_insert_defines.svh
// ----------------------------------------------------------------------------
// sorted_key_record_insert_defines.svh
// Assertion macros shared by the sorted key/record node RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_RECORD_INSERT_DEFINES_SVH
`define SORTED_KEY_RECORD_INSERT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SKRI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SKRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/skri_pkg.sv
// ----------------------------------------------------------------------------
// skri_pkg
// Types and constants for the sorted key/record node.
// ----------------------------------------------------------------------------
package skri_pkg;

   localparam int SKRI_CAPACITY   = 256;
   localparam int SKRI_GROUP_SIZE = 16;

   typedef struct packed {
      logic signed [31:0] key;
      logic [30:0]        page;
      logic [30:0]        slot;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // per-cell control
   typedef struct packed {
      logic ins;
      logic valid;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_GATH,
      S_FIN
   } state_type;

endpackage

// File: hdl/sorted_key_record_insert.sv
// ----------------------------------------------------------------------------
// sorted_key_record_insert
// Sorted key/record node: a chain of entry cells kept in ascending key order.
// ----------------------------------------------------------------------------
//
//  channel | ports  | moves
//  --------+--------+-------------------------------------------------------
//  request | req_*  | one item: insert (key, page, slot) or read (position)
//  result  | rsp_*  | one item per request: status, where, entry, count
//
//  Steps per item: accept; compare in every cell (shift too on an insert
//  that fits) while the first select level registers; second select
//  level (insert position or read entry); result register load. Next
//  item is taken the cycle after. Reset clears only the entry count,
//  control and select hit flags; ready is low in reset. A stalled
//  result holds in the output register; a finished item waits in the
//  last step until that register is free.
module sorted_key_record_insert
   import skri_pkg::*;
#(
   parameter int CAPACITY = SKRI_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [31:0] req_key,
   input  logic [30:0]        req_page_id,
   input  logic [30:0]        req_slot_id,
   input  logic [7:0]         req_position,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_where,
   output logic signed [31:0] rsp_found_key,
   output logic [30:0]        rsp_found_page,
   output logic [30:0]        rsp_found_slot,
   output logic [8:0]         rsp_entry_count
);

   `include "sorted_key_record_insert_defines.svh"

   localparam int IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // position bits
   localparam int CW     = $clog2(CAPACITY + 1);                   // count bits
   localparam int PW     = ENTRY_W + IW;                           // tree payload
   localparam int NGROUP = (CAPACITY + SKRI_GROUP_SIZE - 1) / SKRI_GROUP_SIZE;
   localparam int NPAD   = NGROUP * SKRI_GROUP_SIZE;

   // ---------------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // latched item
   logic        op_action_ff;
   entry_type   op_entry_ff;
   logic [7:0]  op_position_ff;
   logic        full_ff, oor_ff;     // node full / read out of range, pre-item

   // response register
   status_type       rsp_status_ff;
   logic [7:0]       rsp_where_ff;
   entry_type        rsp_entry_ff;
   logic [8:0]       rsp_count_ff;

   // FSM outputs
   logic req_take, cell_ins, g1_en, g2_en, rsp_load;

   // derived
   logic             full_now, oor_now;
   logic [CW+7:0]    pos_w, cnt_w;
   logic [IW+7:0]    idx_w;
   logic [CW+8:0]    cnt_out_w;
   logic [CW-1:0]    count_inc;
   logic             read_live;      // in-range read in its second select step

   assign pos_w     = {{CW{1'b0}}, op_position_ff};
   assign cnt_w     = {8'd0, count_ff};
   assign full_now  = (count_ff == CW'(CAPACITY));
   assign oor_now   = !(pos_w < cnt_w);
   assign count_inc = count_ff + CW'(1);

   // ---------------------------------------------------------------------
   // cell chain
   // ---------------------------------------------------------------------
   entry_type                  cell_entry [CAPACITY];
   logic [CAPACITY-1:0]        cell_lt;
   logic [CAPACITY-1:0]        cell_hit;
   logic [NPAD-1:0]            pad_hit;
   logic [NPAD-1:0][PW-1:0]    pad_pay;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_ctl_type ctl;
      entry_type    left_entry;
      logic         left_lt;

      assign ctl.ins   = cell_ins;
      assign ctl.valid = (count_ff > CW'(i));

      if (i == 0) begin : g_head
         assign left_entry = op_entry_ff;
         assign left_lt    = 1'b1;       // head takes the new entry directly
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_lt    = cell_lt[i-1];
      end

      skri_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_entry  (op_entry_ff),
         .left_entry (left_entry),
         .left_lt    (left_lt),
         .entry_ff   (cell_entry[i]),
         .lt         (cell_lt[i])
      );

      // insert: the one cell where the run of smaller keys ends
      // read: the cell at the requested position
      assign cell_hit[i] = (op_action_ff == ACT_INSERT) ? (!cell_lt[i] && left_lt)
                                                        : (pos_w == (CW+8)'(i));
      assign pad_hit[i]  = cell_hit[i];
      assign pad_pay[i]  = {cell_entry[i], IW'(i)};
   end

   for (genvar i = CAPACITY; i < NPAD; i++) begin : g_pad
      assign pad_hit[i] = 1'b0;
      assign pad_pay[i] = '0;
   end

   // ---------------------------------------------------------------------
   // two-level select tree
   // ---------------------------------------------------------------------
   logic [NGROUP-1:0]          grp_hit;
   logic [NGROUP-1:0][PW-1:0]  grp_pay;
   logic                       sel_hit;
   logic [PW-1:0]              sel_pay;
   entry_type                  sel_entry;
   logic [IW-1:0]              sel_idx;

   for (genvar g = 0; g < NGROUP; g++) begin : g_grp
      skri_gather #(
         .N (SKRI_GROUP_SIZE),
         .W (PW)
      ) u_grp (
         .clock   (clock),
         .reset   (reset),
         .en      (g1_en),
         .hit     (pad_hit[g*SKRI_GROUP_SIZE +: SKRI_GROUP_SIZE]),
         .data    (pad_pay[g*SKRI_GROUP_SIZE +: SKRI_GROUP_SIZE]),
         .hit_ff  (grp_hit[g]),
         .data_ff (grp_pay[g])
      );
   end

   skri_gather #(
      .N (NGROUP),
      .W (PW)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .en      (g2_en),
      .hit     (grp_hit),
      .data    (grp_pay),
      .hit_ff  (sel_hit),
      .data_ff (sel_pay)
   );

   assign sel_entry = sel_pay[PW-1:IW];
   assign sel_idx   = sel_pay[IW-1:0];
   assign idx_w     = {8'd0, sel_idx};

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: state_in = S_GATH;
         S_GATH: state_in = S_FIN;
         S_FIN:  if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_take = 1'b0;
      cell_ins = 1'b0;
      g1_en    = 1'b0;
      g2_en    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: req_take = 1'b1;
         S_EXEC: begin
            cell_ins = (op_action_ff == ACT_INSERT) && !full_now;
            g1_en    = 1'b1;
         end
         S_GATH: g2_en = 1'b1;
         S_FIN:  rsp_load = !rsp_valid_ff || rsp_ready;
         default: req_take = 1'b0;
      endcase
   end

   // no item is taken while reset is held
   assign req_ready = req_take && !reset;
   assign read_live = g2_en && (op_action_ff == ACT_READ) && !oor_ff;

   always_comb begin
      count_in = count_ff;
      if (cell_ins) begin
         count_in = count_inc;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item latch and pre-item checks
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_action_ff     <= req_action;
         op_entry_ff.key  <= req_key;
         op_entry_ff.page <= req_page_id;
         op_entry_ff.slot <= req_slot_id;
         op_position_ff   <= req_position;
      end
      if (state_ff == S_EXEC) begin
         full_ff <= full_now;
         oor_ff  <= oor_now;
      end
   end

   // ---------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------
   assign cnt_out_w = {9'd0, count_ff};

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_count_ff <= cnt_out_w[8:0];
         rsp_entry_ff <= '0;
         if (op_action_ff == ACT_INSERT) begin
            rsp_where_ff  <= full_ff ? 8'd0 : idx_w[7:0];
            rsp_status_ff <= full_ff ? ST_FULL : ST_OK;
         end else begin
            rsp_where_ff <= op_position_ff;
            if (oor_ff) begin
               rsp_status_ff <= ST_RANGE;
            end else begin
               rsp_status_ff <= ST_OK;
               rsp_entry_ff  <= sel_entry;
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_where       = rsp_where_ff;
   assign rsp_found_key   = rsp_entry_ff.key;
   assign rsp_found_page  = rsp_entry_ff.page;
   assign rsp_found_slot  = rsp_entry_ff.slot;
   assign rsp_entry_count = rsp_count_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `SKRI_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count over cap")
   `SKRI_ASSERT_NEXT(a_cnt_step, clock, reset, cell_ins, count_ff == $past(count_inc), "no step")
   `SKRI_ASSERT_NOW(a_one_slot, clock, reset, cell_ins, $onehot(cell_hit), "slot not unique")
   `SKRI_ASSERT_NEXT(a_hit_found, clock, reset, read_live, sel_hit, "read selected no cell")

endmodule

// File: hdl/skri_cell.sv
// ----------------------------------------------------------------------------
// skri_cell
// One node slot: holds an entry, compares it with the new key and shifts.
// ----------------------------------------------------------------------------
module skri_cell
   import skri_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    new_entry,
   input  entry_type    left_entry,
   input  logic         left_lt,
   output entry_type    entry_ff,
   output logic         lt
);

   entry_type entry_in;

   // entry is valid and strictly below the new key
   assign lt = ctl.valid && ($signed(entry_ff.key) < $signed(new_entry.key));

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins && !lt) begin
         entry_in = left_lt ? new_entry : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: hdl/skri_gather.sv
// ----------------------------------------------------------------------------
// skri_gather
// Registered one-hot select: ORs together the payloads whose hit is set.
// ----------------------------------------------------------------------------
module skri_gather
   import skri_pkg::*;
#(
   parameter int N = SKRI_GROUP_SIZE,
   parameter int W = ENTRY_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic [N-1:0]        hit,
   input  logic [N-1:0][W-1:0] data,
   output logic                hit_ff,
   output logic [W-1:0]        data_ff
);

   logic         hit_in;
   logic [W-1:0] data_in;

   always_comb begin
      hit_in  = hit_ff;
      data_in = data_ff;
      if (en) begin
         hit_in  = |hit;
         data_in = '0;
         for (int n = 0; n < N; n++) begin
            data_in = data_in | (data[n] & {W{hit[n]}});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      data_ff <= data_in;
   end

endmodule
